// File: src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and helper functions of the texture span shader.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int LANES             = 8;
  localparam int TEXEL_DEPTH_DEF   = 16384;

  localparam int IN_DATA_W         = 184;
  localparam int IN_USER_W         = 2;
  localparam int OUT_DATA_W        = 264;
  localparam int CFG_ADDR_W        = 4;
  localparam int CFG_DATA_W        = 32;

  // Item kinds carried in tuser.
  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_DRAW_OPQ  = 2'd1;
  localparam logic [1:0] OP_DRAW_TRN  = 2'd2;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_COORD_SHIFT = 2'd0;
  localparam logic [1:0] REG_U_WRAP_MASK = 2'd1;
  localparam logic [1:0] REG_V_ROW_MASK  = 2'd2;

  localparam logic [2:0]  COORD_SHIFT_RST = 3'd7;
  localparam logic [6:0]  U_WRAP_MASK_RST = 7'd127;
  localparam logic [13:0] V_ROW_MASK_RST  = 14'h3F80;

  // Control word that travels down the pipeline beside the lane data.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic [7:0] shade;
  } tss_ctl_t;

  // Reduces an address below 8*depth to its place in the store.
  function automatic logic [16:0] mod_depth(input logic [16:0] x, input int unsigned depth);
    logic [16:0] r;
    r = x;
    if (r >= 17'(4 * depth)) r = r - 17'(4 * depth);
    if (r >= 17'(2 * depth)) r = r - 17'(2 * depth);
    if (r >= 17'(depth))     r = r - 17'(depth);
    return r;
  endfunction

  // Scales each byte of a texel by shade/256.
  function automatic logic [31:0] shade_word(input logic [31:0] texel, input logic [7:0] shade);
    logic [31:0] res;
    logic [15:0] prod;
    res = '0;
    for (int b = 0; b < 4; b++) begin
      prod = texel[8*b +: 8] * shade;
      res[8*b +: 8] = prod[15:8];
    end
    return res;
  endfunction

  function automatic logic is_draw(input logic [1:0] op);
    return (op == OP_DRAW_OPQ) || (op == OP_DRAW_TRN);
  endfunction

endpackage

// File: src/tss_lane.sv
// ----------------------------------------------------------------------------
// tss_lane
// One pixel lane: coordinate step, texel address, private copy of the texture
// store, and the per-byte shade multiply.
// ----------------------------------------------------------------------------
module tss_lane #(
  parameter int TEXEL_DEPTH = tss_pkg::TEXEL_DEPTH_DEF,
  parameter int LANE_IDX    = 0,
  parameter int AW          = $clog2(TEXEL_DEPTH)
) (
  input  logic               clk,
  input  logic               adv,
  input  tss_pkg::tss_ctl_t  ctl1,
  input  tss_pkg::tss_ctl_t  ctl2,
  input  logic [31:0]        u_start,
  input  logic [31:0]        v_start,
  input  logic [31:0]        u_step,
  input  logic [31:0]        v_step,
  input  logic [2:0]         coord_shift,
  input  logic [6:0]         u_wrap_mask,
  input  logic [13:0]        v_row_mask,
  input  logic [AW-1:0]      load_addr,
  input  logic [31:0]        load_value,
  output logic [31:0]        pixel_r,
  output logic               texel_nz
);
  import tss_pkg::*;

  logic [31:0]   u_r, v_r;
  logic [31:0]   u_nxt, v_nxt;
  logic [31:0]   u_shifted;
  logic [14:0]   addr_sum;
  logic [16:0]   addr_red;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rdata_r;
  logic [31:0]   pixel_nxt;
  logic [31:0]   tex_mem [TEXEL_DEPTH];

  // Lane i sits i steps from the start coordinate.
  assign u_nxt = u_start + u_step * 32'(LANE_IDX);
  assign v_nxt = v_start + v_step * 32'(LANE_IDX);

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
  end

  assign u_shifted = u_r >> coord_shift;
  assign addr_sum  = {8'd0, u_shifted[6:0] & u_wrap_mask} + {1'b0, v_r[13:0] & v_row_mask};
  assign addr_red  = mod_depth({2'd0, addr_sum}, TEXEL_DEPTH);
  assign rd_addr   = addr_red[AW-1:0];

  // Loads write every lane copy at once, so all eight fetches happen in the same cycle.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl1.valid && (ctl1.op == OP_LOAD)) begin
        tex_mem[load_addr] <= load_value;
      end else begin
        rdata_r <= tex_mem[rd_addr];
      end
    end
  end

  assign texel_nz  = |rdata_r;
  assign pixel_nxt = (ctl2.valid && is_draw(ctl2.op)) ? shade_word(rdata_r, ctl2.shade) : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule

// File: src/tss_merge.sv
// ----------------------------------------------------------------------------
// tss_merge
// Forms the write mask (all lanes for opaque draws, the lane texel flags for
// transparent draws) and holds the output word valid until it is taken.
// ----------------------------------------------------------------------------
module tss_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  tss_pkg::tss_ctl_t           ctl2,
  input  logic [tss_pkg::LANES-1:0]   lane_nz,
  output logic [tss_pkg::LANES-1:0]   write_mask_r,
  output logic                        out_valid_r
);
  import tss_pkg::*;

  logic [LANES-1:0] write_mask_nxt;
  logic             out_valid_nxt;

  always_comb begin
    write_mask_nxt = '0;
    if (ctl2.valid) begin
      unique case (ctl2.op)
        OP_DRAW_OPQ: write_mask_nxt = '1;
        OP_DRAW_TRN: write_mask_nxt = lane_nz;
        default:     write_mask_nxt = '0;
      endcase
    end
  end

  assign out_valid_nxt = adv ? ctl2.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      write_mask_r <= write_mask_nxt;
    end
  end

endmodule

// File: src/texture_span8_shade_blend.sv
// An accepted word passes the ctl1, ctl2 and output registers to out_tvalid.
// Throughput: one word per cycle; every lane holds its own copy of the
// texture store, so a draw's eight texel fetches happen in the same cycle.
// The pipeline advances only while the output register is empty or taken.
// Reset clears the pipeline valid bits and the configuration registers; the
// texture store is not cleared and must be loaded before it is drawn from.
// ----------------------------------------------------------------------------
// texture_span8_shade_blend
// Eight-lane affine texture span shader with a loadable texture store.
// ----------------------------------------------------------------------------
module texture_span8_shade_blend #(
  parameter int TEXEL_DEPTH = tss_pkg::TEXEL_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // load_index[13:0], load_value[45:14], u_start[77:46], v_start[109:78],
  // u_step[141:110], v_step[173:142], shade[181:174], zero fill [183:182]
  input  logic [tss_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[1:0]
  input  logic [tss_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel0[31:0] .. pixel7[255:224], write_mask[263:256]
  output logic [tss_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tss_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tss_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tss_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import tss_pkg::*;

  localparam int AW = $clog2(TEXEL_DEPTH);

  logic [2:0]  coord_shift_r;
  logic [6:0]  u_wrap_mask_r;
  logic [13:0] v_row_mask_r;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  logic        adv;
  tss_ctl_t    ctl1_r, ctl2_r;
  tss_ctl_t    ctl1_nxt;
  logic [AW-1:0] load_addr_r;
  logic [31:0]   load_value_r;
  logic [16:0]   load_red;

  logic [13:0] f_load_index;
  logic [31:0] f_load_value, f_u_start, f_v_start, f_u_step, f_v_step;
  logic [7:0]  f_shade;

  logic [LANES-1:0] lane_nz;
  logic [31:0]      lane_pixel [LANES];
  logic [LANES-1:0] write_mask_r;
  logic             out_valid_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_shift_r <= COORD_SHIFT_RST;
      u_wrap_mask_r <= U_WRAP_MASK_RST;
      v_row_mask_r  <= V_ROW_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COORD_SHIFT: coord_shift_r <= cfg_pwdata[2:0];
        REG_U_WRAP_MASK: u_wrap_mask_r <= cfg_pwdata[6:0];
        REG_V_ROW_MASK:  v_row_mask_r  <= cfg_pwdata[13:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COORD_SHIFT: cfg_prdata = {29'd0, coord_shift_r};
      REG_U_WRAP_MASK: cfg_prdata = {25'd0, u_wrap_mask_r};
      REG_V_ROW_MASK:  cfg_prdata = {18'd0, v_row_mask_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Input word unpacking.
  assign f_load_index = in_tdata[13:0];
  assign f_load_value = in_tdata[45:14];
  assign f_u_start    = in_tdata[77:46];
  assign f_v_start    = in_tdata[109:78];
  assign f_u_step     = in_tdata[141:110];
  assign f_v_step     = in_tdata[173:142];
  assign f_shade      = in_tdata[181:174];

  // The whole pipeline moves together whenever the output register can take
  // a word.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign ctl1_nxt.valid = in_tvalid;
  assign ctl1_nxt.op    = in_tuser[1:0];
  assign ctl1_nxt.shade = f_shade;
  assign load_red       = mod_depth({3'd0, f_load_index}, TEXEL_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      load_addr_r  <= load_red[AW-1:0];
      load_value_r <= f_load_value;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tss_lane #(
      .TEXEL_DEPTH (TEXEL_DEPTH),
      .LANE_IDX    (i),
      .AW          (AW)
    ) u_lane (
      .clk         (clk),
      .adv         (adv),
      .ctl1        (ctl1_r),
      .ctl2        (ctl2_r),
      .u_start     (f_u_start),
      .v_start     (f_v_start),
      .u_step      (f_u_step),
      .v_step      (f_v_step),
      .coord_shift (coord_shift_r),
      .u_wrap_mask (u_wrap_mask_r),
      .v_row_mask  (v_row_mask_r),
      .load_addr   (load_addr_r),
      .load_value  (load_value_r),
      .pixel_r     (lane_pixel[i]),
      .texel_nz    (lane_nz[i])
    );
    assign out_tdata[32*i +: 32] = lane_pixel[i];
  end

  tss_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctl2         (ctl2_r),
    .lane_nz      (lane_nz),
    .write_mask_r (write_mask_r),
    .out_valid_r  (out_valid_r)
  );

  assign out_tdata[32*LANES +: LANES] = write_mask_r;
  assign out_tvalid = out_valid_r;

endmodule
